### rtl/core/sorted_list_priority_queue_macros.svh
// sorted_list_priority_queue_macros.svh
// assertion macros shared by the priority queue rtl; they expect clk and rst in scope
`ifndef SORTED_LIST_PRIORITY_QUEUE_MACROS_SVH
`define SORTED_LIST_PRIORITY_QUEUE_MACROS_SVH

// condition holds on every clock edge out of reset
`define SLPQ_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define SLPQ_ASSERT_SAME(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// consequent holds in the cycle after the antecedent
`define SLPQ_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/core/slpq_pkg.sv
// slpq_pkg.sv
// command and status codes, data width and cell control struct for the priority queue
// no dependencies
`timescale 1ns / 1ps

package slpq_pkg;

  localparam int DATA_W  = 32;
  localparam int CMD_W   = 2;
  localparam int STAT_W  = 2;
  localparam int COUNT_W = 5;

  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT = 2'd0,
    CMD_SEARCH = 2'd1,
    CMD_REMOVE = 2'd2
  } cmd_t;

  typedef enum logic [STAT_W-1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_t;

  // broadcast to every cell of the row
  typedef struct packed {
    logic                     ins;
    logic                     rem;
    logic signed [DATA_W-1:0] value;
  } cell_ctrl_t;

endpackage

### rtl/core/slpq_req_if.sv
// slpq_req_if.sv
// request channel of the priority queue: command and value with valid/ready
// depends on slpq_pkg
`timescale 1ns / 1ps

interface slpq_req_if
  import slpq_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [CMD_W-1:0]         command;
  logic signed [DATA_W-1:0] value;

  modport source (output valid, output command, output value, input ready);
  modport sink (input valid, input command, input value, output ready);
endinterface

### rtl/core/slpq_rsp_if.sv
// slpq_rsp_if.sv
// result channel of the priority queue: status, found, popped value and count
// depends on slpq_pkg
`timescale 1ns / 1ps

interface slpq_rsp_if
  import slpq_pkg::*;
();
  logic                     valid;
  logic                     ready;
  logic [STAT_W-1:0]        status;
  logic                     found;
  logic signed [DATA_W-1:0] popped_value;
  logic [COUNT_W-1:0]       entry_count;

  modport source (output valid, output status, output found, output popped_value,
                  output entry_count, input ready);
  modport sink (input valid, input status, input found, input popped_value,
                input entry_count, output ready);
endinterface

### rtl/core/slpq_cell.sv
// slpq_cell.sv
// one compare-and-shift cell of the sorted row: holds one entry, trades with neighbors
// depends on slpq_pkg
`timescale 1ns / 1ps

module slpq_cell
  import slpq_pkg::*;
(
  input  logic                     clk,
  input  cell_ctrl_t               ctrl,
  input  logic                     occupied,
  input  logic signed [DATA_W-1:0] left_data,
  input  logic                     left_lt,
  input  logic signed [DATA_W-1:0] right_data,
  output logic signed [DATA_W-1:0] data,
  output logic                     lt,
  output logic                     eq
);

  logic signed [DATA_W-1:0] data_next;

  // compare the held entry against the broadcast value
  assign lt = occupied && (data < ctrl.value);
  assign eq = occupied && (data == ctrl.value);

  // insert: keep if smaller, take the value at the slot boundary, else shift right
  // remove: take the right neighbor's entry
  always_comb begin
    data_next = data;
    if (ctrl.ins) begin
      if (lt) begin
        data_next = data;
      end else if (left_lt) begin
        data_next = ctrl.value;
      end else begin
        data_next = left_data;
      end
    end else if (ctrl.rem) begin
      data_next = right_data;
    end
  end

  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

### rtl/core/sorted_list_priority_queue.sv
// sorted_list_priority_queue: ascending-order store of signed 32-bit values in a row of cells
// an accepted request waits in the EXEC state until the output register is free, then its result is registered there
// no new request is accepted until the held one has executed, set by the single operation register feeding the row
// a finished result may wait in the output register while the next request is accepted
// reset (synchronous): entry count clears to zero; cell contents are left unset and never read
// depends on slpq_pkg, slpq_req_if, slpq_rsp_if, slpq_cell and the macro header
`timescale 1ns / 1ps

`include "sorted_list_priority_queue_macros.svh"

module sorted_list_priority_queue
  import slpq_pkg::*;
#(
  parameter int CAPACITY = 16
) (
  input  logic       clk,
  input  logic       rst,
  slpq_req_if.sink   request,
  slpq_rsp_if.source result
);

  localparam int CW = $clog2(CAPACITY + 1);

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_EXEC = 2'b10
  } state_t;

  state_t                   state;
  state_t                   state_next;
  logic [CMD_W-1:0]         cmd_q;
  logic signed [DATA_W-1:0] value_q;
  logic [CW-1:0]            count;
  logic [CW-1:0]            count_next;

  logic                     out_valid;
  logic [STAT_W-1:0]        out_status;
  logic                     out_found;
  logic signed [DATA_W-1:0] out_popped;
  logic [COUNT_W-1:0]       out_count;

  logic                     accept;
  logic                     fire;
  logic                     full;
  logic                     empty;
  cell_ctrl_t               ctrl;
  logic [STAT_W-1:0]        status_next;
  logic [CW+COUNT_W-1:0]    count_ext;

  logic signed [DATA_W-1:0] cell_data [CAPACITY];
  logic [CAPACITY-1:0]      cell_lt;
  logic [CAPACITY-1:0]      cell_eq;

  // handshake and operation timing
  assign request.ready = (state == S_IDLE);
  assign accept        = request.valid && request.ready;
  assign fire          = (state == S_EXEC) && (!out_valid || result.ready);

  assign full  = (count == CW'(CAPACITY));
  assign empty = (count == '0);

  // control broadcast to the cell row
  always_comb begin
    ctrl.value = value_q;
    ctrl.ins   = fire && (cmd_q == CMD_INSERT) && !full;
    ctrl.rem   = fire && (cmd_q == CMD_REMOVE) && !empty;
  end

  // row of cells
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam logic [CW-1:0] IDX = CW'(i);
    logic signed [DATA_W-1:0] left_data;
    logic                     left_lt;
    logic signed [DATA_W-1:0] right_data;

    if (i == 0) begin : g_head
      assign left_data = value_q;
      assign left_lt   = 1'b1;
    end else begin : g_body
      assign left_data = cell_data[i-1];
      assign left_lt   = cell_lt[i-1];
    end

    if (i == CAPACITY - 1) begin : g_tail
      assign right_data = cell_data[i];
    end else begin : g_inner
      assign right_data = cell_data[i+1];
    end

    slpq_cell u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .occupied   (count > IDX),
      .left_data  (left_data),
      .left_lt    (left_lt),
      .right_data (right_data),
      .data       (cell_data[i]),
      .lt         (cell_lt[i]),
      .eq         (cell_eq[i])
    );
  end

  // status and count update
  always_comb begin
    status_next = ST_DONE;
    count_next  = count;
    case (cmd_q)
      CMD_INSERT: begin
        if (full) begin
          status_next = ST_FULL;
        end else begin
          count_next = count + 1'b1;
        end
      end
      CMD_REMOVE: begin
        if (empty) begin
          status_next = ST_EMPTY;
        end else begin
          count_next = count - 1'b1;
        end
      end
      default: begin
        status_next = ST_DONE;
      end
    endcase
  end

  assign count_ext = {{COUNT_W{1'b0}}, count_next};

  // state machine
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EXEC;
        end
      end
      S_EXEC: begin
        if (fire) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (fire) begin
        count     <= count_next;
        out_valid <= 1'b1;
      end else if (result.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // request hold register
  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_q   <= request.command;
      value_q <= request.value;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (fire) begin
      out_status <= status_next;
      out_found  <= (cmd_q == CMD_SEARCH) && (|cell_eq);
      out_popped <= ctrl.rem ? cell_data[0] : '0;
      out_count  <= count_ext[COUNT_W-1:0];
    end
  end

  assign result.valid        = out_valid;
  assign result.status       = out_status;
  assign result.found        = out_found;
  assign result.popped_value = out_popped;
  assign result.entry_count  = out_count;

  // checks
  `SLPQ_ASSERT_ALWAYS(a_count_bound, count <= CW'(CAPACITY), "entry count above capacity")
  `SLPQ_ASSERT_NEXT(a_accept_exec, accept, state == S_EXEC, "accepted request not executing")
  `SLPQ_ASSERT_NEXT(a_count_hold, !fire, $stable(count), "count changed without an operation")
  `SLPQ_ASSERT_SAME(a_full_flag, out_valid && (out_status == ST_FULL), full,
                    "full status while store not full")
  `SLPQ_ASSERT_SAME(a_fire_room, fire, !out_valid || result.ready,
                    "result overwritten before taken")

endmodule
